### src/auma_pkg.sv
package auma_pkg;

  // Item and register widths
  localparam int RAW_W   = 16;
  localparam int SPAN_W  = 16;
  localparam int TURN_W  = 8;
  localparam int MULT_W  = TURN_W + 1;
  localparam int ANGLE_W = 25;
  localparam int MODE_W  = 2;

  // Averaging window
  localparam int WINDOW_DEPTH = 20;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W        = ANGLE_W + $clog2(WINDOW_DEPTH);

  // Divide by the window depth as a multiply by a rounded-up reciprocal
  localparam int MAG_W     = SUM_W;
  localparam int DIV_SHIFT = MAG_W + $clog2(WINDOW_DEPTH);
  localparam int RECIP_W   = MAG_W + 1;
  localparam longint unsigned RECIP =
    ((64'd1 << DIV_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;

  // Register reset values
  localparam logic [RAW_W-1:0]  LOW_EDGE_RST  = 16'd1000;
  localparam logic [RAW_W-1:0]  MID_EDGE_RST  = 16'd18000;
  localparam logic [RAW_W-1:0]  HIGH_EDGE_RST = 16'd35000;
  localparam logic [SPAN_W-1:0] FULL_TURN_RST = 16'd36000;

  // Stream payload
  localparam int OUT_TDATA_W = ((2 * ANGLE_W + MODE_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CFG_LOW_EDGE  = 2'd0,
    CFG_MID_EDGE  = 2'd1,
    CFG_HIGH_EDGE = 2'd2,
    CFG_FULL_TURN = 2'd3
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_START = 2'd0,
    MODE_DOWN  = 2'd1,
    MODE_UP    = 2'd2,
    MODE_TRACK = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ZONE_NONE = 3'd0,
    ZONE_LOW  = 3'd1,
    ZONE_LMID = 3'd2,
    ZONE_UMID = 3'd3,
    ZONE_HIGH = 3'd4
  } zone_e;

  // Unwrap stage result
  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    mode_e                     mode;
  } unwrap_res_t;

  // Window stage result
  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [SUM_W-1:0]   sum;
    mode_e                     mode;
    logic                      avg;
  } win_res_t;

endpackage

### src/angle_unwrap_moving_average_core.sv
// Pipeline: an accepted item passes through the input register, the unwrap
//   stage, the window stage and the result register, in that order.
// Throughput: one item per cycle; each stage holds one item and stalls only
//   when the stage after it is full and not draining.
// Reset: asynchronous, active low; registers return to their defaults, turn
//   count and crossing mode clear, and the window waits for a first item.
module angle_unwrap_moving_average_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [1:0]                            cfg_index_i,
  input  logic [auma_pkg::RAW_W-1:0]            cfg_data_i,
  // Input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [auma_pkg::RAW_W-1:0]            s_axis_tdata,  // [15:0] raw_angle
  // Result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [24:0] unwrapped_angle, [49:25] filtered_angle, [51:50] crossing_mode, rest zero
  output logic [auma_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tuser   // [0] sample_averaged
);
  import auma_pkg::*;

  logic              v0_q, v1_q, v2_q, v3_q;
  logic              en0, en1, en2, en3;
  logic [RAW_W-1:0]  raw_q;
  unwrap_res_t       unw_res;
  win_res_t          win_res;
  logic signed [ANGLE_W-1:0] angle, mean;
  mode_e             mode;
  logic              avg;

  // Per-stage load enables
  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;

  assign s_axis_tready = en0;
  assign cfg_ready_o   = 1'b1;

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en0) v0_q <= s_axis_tvalid;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && en0) begin
      raw_q <= s_axis_tdata;
    end
  end

  auma_unwrap u_unwrap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .adv_i       (v0_q && en1),
    .raw_i       (raw_q),
    .res_o       (unw_res)
  );

  auma_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (v1_q && en2),
    .in_i   (unw_res),
    .res_o  (win_res)
  );

  auma_mean u_mean (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (v2_q && en3),
    .in_i    (win_res),
    .angle_o (angle),
    .mean_o  (mean),
    .mode_o  (mode),
    .avg_o   (avg)
  );

  // Result stream
  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * ANGLE_W - MODE_W){1'b0}}, mode, mean, angle};
  assign m_axis_tuser  = avg;

`ifndef SYNTHESIS
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the result side drains");
`endif

endmodule

### src/auma_unwrap.sv
module auma_unwrap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  auma_pkg::cfg_idx_e            cfg_index_i,
  input  logic [auma_pkg::RAW_W-1:0]    cfg_data_i,
  input  logic                          adv_i,
  input  logic [auma_pkg::RAW_W-1:0]    raw_i,
  output auma_pkg::unwrap_res_t         res_o
);
  import auma_pkg::*;

  logic [RAW_W-1:0]  low_edge_q, mid_edge_q, high_edge_q;
  logic [SPAN_W-1:0] full_turn_q;
  logic [TURN_W-1:0] turns_q, turns_d;
  mode_e             mode_q, mode_d, mode_x;
  zone_e             prev_q, zone;
  logic signed [MULT_W-1:0]         mult;
  logic signed [SPAN_W+MULT_W:0]    prod;
  logic signed [SPAN_W+MULT_W:0]    angle_full;
  unwrap_res_t       res_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_edge_q  <= LOW_EDGE_RST;
      mid_edge_q  <= MID_EDGE_RST;
      high_edge_q <= HIGH_EDGE_RST;
      full_turn_q <= FULL_TURN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LOW_EDGE:  low_edge_q  <= cfg_data_i;
        CFG_MID_EDGE:  mid_edge_q  <= cfg_data_i;
        CFG_HIGH_EDGE: high_edge_q <= cfg_data_i;
        CFG_FULL_TURN: full_turn_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zone of the sample
  always_comb begin
    if (raw_i < low_edge_q) begin
      zone = ZONE_LOW;
    end else if (raw_i < mid_edge_q) begin
      zone = ZONE_LMID;
    end else if (raw_i <= high_edge_q) begin
      zone = ZONE_UMID;
    end else begin
      zone = ZONE_HIGH;
    end
  end

  // Crossing mode, turn count and turn multiple
  always_comb begin
    mode_x = mode_q;
    if (zone == ZONE_LOW && prev_q == ZONE_LMID) begin
      mode_x = MODE_DOWN;
    end else if (zone == ZONE_HIGH && prev_q == ZONE_UMID) begin
      mode_x = MODE_UP;
    end
    mode_d  = mode_x;
    turns_d = turns_q;
    mult    = '0;
    case (mode_x)
      MODE_START: begin
        if (raw_i >= low_edge_q && raw_i < high_edge_q) mode_d = MODE_TRACK;
      end
      MODE_DOWN: begin
        if (zone == ZONE_LMID && prev_q == ZONE_LOW) begin
          mode_d = MODE_TRACK;
        end else if (zone == ZONE_UMID && prev_q == ZONE_HIGH) begin
          turns_d = turns_q - TURN_W'(1);
          mode_d  = MODE_TRACK;
        end
        mult = $signed({turns_d[TURN_W-1], turns_d});
        if (raw_i >= low_edge_q && raw_i > high_edge_q) mult = mult - MULT_W'(1);
      end
      MODE_UP: begin
        if (zone == ZONE_LMID && prev_q == ZONE_LOW) begin
          turns_d = turns_q + TURN_W'(1);
          mode_d  = MODE_TRACK;
        end else if (zone == ZONE_UMID && prev_q == ZONE_HIGH) begin
          mode_d = MODE_TRACK;
        end
        mult = $signed({turns_d[TURN_W-1], turns_d});
        if (raw_i < low_edge_q) mult = mult + MULT_W'(1);
      end
      MODE_TRACK: begin
        mult = $signed({turns_q[TURN_W-1], turns_q});
      end
      default: ;
    endcase
  end

  // Multi-turn angle
  assign prod       = $signed({1'b0, full_turn_q}) * mult;
  assign angle_full = prod + $signed({{(MULT_W + 1){1'b0}}, raw_i});

  // Unwrap state advances with each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turns_q <= '0;
      mode_q  <= MODE_START;
      prev_q  <= ZONE_NONE;
    end else if (adv_i) begin
      turns_q <= turns_d;
      mode_q  <= mode_d;
      prev_q  <= zone;
    end
  end

  // Stage register
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q.angle <= angle_full[ANGLE_W-1:0];
      res_q.mode  <= mode_d;
    end
  end

  assign res_o = res_q;

endmodule

### src/auma_window.sv
module auma_window (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  auma_pkg::unwrap_res_t  in_i,
  output auma_pkg::win_res_t     res_o
);
  import auma_pkg::*;

  localparam logic signed [SUM_W-1:0] DEPTH_S  = SUM_W'(WINDOW_DEPTH);
  localparam logic [PTR_W-1:0]        PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0]        CNT_FULL = CNT_W'(WINDOW_DEPTH);

  logic signed [ANGLE_W-1:0] store_q [WINDOW_DEPTH];
  logic signed [ANGLE_W-1:0] fill_q, fill_d, old;
  logic [PTR_W-1:0]          ptr_q, ptr_d;
  logic [CNT_W-1:0]          wsf_q, wsf_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d, angle_ext;
  logic                      filled_q, filled_d;
  logic                      avg, wr;
  win_res_t                  res_q;

  // Entries not yet rewritten since the fill read as the fill value
  assign old       = (wsf_q == CNT_FULL) ? store_q[ptr_q] : fill_q;
  assign angle_ext = SUM_W'(in_i.angle);

  always_comb begin
    fill_d   = fill_q;
    ptr_d    = ptr_q;
    wsf_d    = wsf_q;
    sum_d    = sum_q;
    filled_d = filled_q;
    avg      = 1'b0;
    wr       = 1'b0;
    if (!filled_q) begin
      // First item fills the whole window
      fill_d   = in_i.angle;
      ptr_d    = '0;
      wsf_d    = '0;
      sum_d    = angle_ext * DEPTH_S;
      filled_d = 1'b1;
      avg      = 1'b1;
    end else if (in_i.mode != MODE_START) begin
      sum_d = sum_q + angle_ext - SUM_W'(old);
      ptr_d = (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
      wsf_d = (wsf_q == CNT_FULL) ? wsf_q : wsf_q + CNT_W'(1);
      avg   = 1'b1;
      wr    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      ptr_q    <= '0;
      wsf_q    <= '0;
      sum_q    <= '0;
      filled_q <= 1'b0;
    end else if (adv_i) begin
      fill_q   <= fill_d;
      ptr_q    <= ptr_d;
      wsf_q    <= wsf_d;
      sum_q    <= sum_d;
      filled_q <= filled_d;
    end
  end

  // Window entries
  always_ff @(posedge clk_i) begin
    if (adv_i && wr) begin
      store_q[ptr_q] <= in_i.angle;
    end
  end

  // Stage register
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q.angle <= in_i.angle;
      res_q.sum   <= sum_d;
      res_q.mode  <= in_i.mode;
      res_q.avg   <= avg;
    end
  end

  assign res_o = res_q;

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_LAST) else $error("window pointer out of range");
  a_wsf_tracks_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filled_q && wsf_q != CNT_FULL) |-> (ptr_q == wsf_q[PTR_W-1:0]))
    else $error("write pointer and fill count disagree");
  a_empty_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !filled_q |-> (wsf_q == '0 && ptr_q == '0 && sum_q == '0))
    else $error("window state set before first item");
`endif

endmodule

### src/auma_mean.sv
module auma_mean (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  adv_i,
  input  auma_pkg::win_res_t                    in_i,
  output logic signed [auma_pkg::ANGLE_W-1:0]   angle_o,
  output logic signed [auma_pkg::ANGLE_W-1:0]   mean_o,
  output auma_pkg::mode_e                       mode_o,
  output logic                                  avg_o
);
  import auma_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);

  logic [MAG_W-1:0]             mag;
  logic [MAG_W+RECIP_W-1:0]     prod;
  logic [ANGLE_W-1:0]           quo;
  logic signed [ANGLE_W-1:0]    mean_d, held_q, angle_q;
  mode_e                        mode_q;
  logic                         avg_q;

  // Mean truncated toward zero: divide the magnitude, restore the sign
  assign mag    = in_i.sum[SUM_W-1] ? MAG_W'(-in_i.sum) : MAG_W'(in_i.sum);
  assign prod   = mag * RECIP_C;
  assign quo    = prod[DIV_SHIFT +: ANGLE_W];
  assign mean_d = in_i.sum[SUM_W-1] ? -$signed(quo) : $signed(quo);

  // Held mean
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (adv_i && in_i.avg) begin
      held_q <= mean_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      angle_q <= in_i.angle;
      mode_q  <= in_i.mode;
      avg_q   <= in_i.avg;
    end
  end

  assign angle_o = angle_q;
  assign mean_o  = held_q;
  assign mode_o  = mode_q;
  assign avg_o   = avg_q;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import auma_pkg::*;

  // Result fields of one item, as carried on the result stream
  typedef struct {
    logic signed [ANGLE_W-1:0] unwrapped;
    logic signed [ANGLE_W-1:0] filtered;
    mode_e                     mode;
    logic                      averaged;
  } angle_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_index_i;
  logic [RAW_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [RAW_W-1:0]       s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  angle_unwrap_moving_average_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Shadow copy of the registers
  logic [RAW_W-1:0]  edge_lo;
  logic [RAW_W-1:0]  edge_mid;
  logic [RAW_W-1:0]  edge_hi;
  logic [SPAN_W-1:0] turn_span;

  // Shadow copy of the unwrap and averaging state
  longint                   window_q [WINDOW_DEPTH];
  int                       slot_q;
  longint                   window_sum_q;
  longint                   mean_q;
  logic signed [TURN_W-1:0] turn_count_q;
  mode_e                    mode_q;
  zone_e                    last_zone_q;
  bit                       window_primed_q;

  angle_result_t expected_angles[$];
  int            error_count;
  int            shaft_pos;

  // Idling controls for the sender and the receiver
  bit send_gaps_on;
  bit recv_stalls_on;
  bit hold_request;
  int hold_left;
  int stall_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("angle_unwrap_moving_average_core test failed");
    $finish;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Unwrap one raw sample and update the averaging window
  function automatic angle_result_t unwrap_and_average(input logic [RAW_W-1:0] raw);
    zone_e         zone;
    int            mult;
    longint        angle;
    angle_result_t res;
    res.averaged = 1'b0;
    mult = 0;

    if (raw < edge_lo) zone = ZONE_LOW;
    else if (raw < edge_mid) zone = ZONE_LMID;
    else if (raw <= edge_hi) zone = ZONE_UMID;
    else zone = ZONE_HIGH;

    // crossings into the outer zones
    if (zone == ZONE_LOW && last_zone_q == ZONE_LMID) mode_q = MODE_DOWN;
    else if (zone == ZONE_HIGH && last_zone_q == ZONE_UMID) mode_q = MODE_UP;

    case (mode_q)
      MODE_START: begin
        if (raw >= edge_lo && raw < edge_hi) mode_q = MODE_TRACK;
      end
      MODE_DOWN: begin
        if (zone == ZONE_LMID && last_zone_q == ZONE_LOW) begin
          mode_q = MODE_TRACK;
        end else if (zone == ZONE_UMID && last_zone_q == ZONE_HIGH) begin
          turn_count_q = turn_count_q - TURN_W'(1);
          mode_q = MODE_TRACK;
        end
        mult = int'(turn_count_q);
        if (raw >= edge_lo && raw > edge_hi) mult = mult - 1;
      end
      MODE_UP: begin
        if (zone == ZONE_LMID && last_zone_q == ZONE_LOW) begin
          turn_count_q = turn_count_q + TURN_W'(1);
          mode_q = MODE_TRACK;
        end else if (zone == ZONE_UMID && last_zone_q == ZONE_HIGH) begin
          mode_q = MODE_TRACK;
        end
        mult = int'(turn_count_q);
        if (raw < edge_lo) mult = mult + 1;
      end
      default: begin
        mult = int'(turn_count_q);
      end
    endcase
    last_zone_q = zone;
    angle = longint'(raw) + longint'(turn_span) * longint'(mult);

    // first sample fills the window, later ones replace the oldest entry
    if (!window_primed_q) begin
      foreach (window_q[i]) window_q[i] = angle;
      slot_q = 0;
      window_sum_q = angle * WINDOW_DEPTH;
      mean_q = angle;
      window_primed_q = 1'b1;
      res.averaged = 1'b1;
    end else if (mode_q != MODE_START) begin
      window_sum_q = window_sum_q + angle - window_q[slot_q];
      window_q[slot_q] = angle;
      slot_q = (slot_q + 1 == WINDOW_DEPTH) ? 0 : slot_q + 1;
      mean_q = window_sum_q / WINDOW_DEPTH;
      res.averaged = 1'b1;
    end

    res.unwrapped = angle[ANGLE_W-1:0];
    res.filtered  = mean_q[ANGLE_W-1:0];
    res.mode      = mode_q;
    return res;
  endfunction

  // Send one item; starts and ends at a falling edge, tvalid left high
  task automatic send_raw(input logic [RAW_W-1:0] raw);
    int gap;
    gap = send_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_angles.push_back(unwrap_and_average(raw));
    @(negedge clk_i);
  endtask

  // Drop tvalid and wait for every expected result plus the pipeline depth
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_angles.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One register write; leaves cfg_valid_i high
  task automatic write_reg(input cfg_idx_e idx, input logic [RAW_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LOW_EDGE:  edge_lo   = value;
      CFG_MID_EDGE:  edge_mid  = value;
      CFG_HIGH_EDGE: edge_hi   = value;
      CFG_FULL_TURN: turn_span = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Program all four registers; only called with the block idle
  task automatic set_registers(input logic [RAW_W-1:0] lo, input logic [RAW_W-1:0] mid,
                               input logic [RAW_W-1:0] hi, input logic [SPAN_W-1:0] span);
    drain_results();
    write_reg(CFG_LOW_EDGE, lo);
    write_reg(CFG_MID_EDGE, mid);
    write_reg(CFG_HIGH_EDGE, hi);
    write_reg(CFG_FULL_TURN, span);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Move the shaft in random steps, mixing in arbitrary samples
  task automatic rotate(input int count, input int fwd_pct, input int step_lo,
                        input int step_hi, input int noise_pct);
    int modulus;
    int step;
    for (int k = 0; k < count; k++) begin
      modulus = (turn_span == 0) ? 65536 : int'(turn_span);
      if (int'($urandom_range(0, 99)) < noise_pct) begin
        send_raw(RAW_W'($urandom_range(0, 65535)));
      end else begin
        step = $urandom_range(step_lo, step_hi);
        if (int'($urandom_range(0, 99)) < fwd_pct) shaft_pos = shaft_pos + step;
        else shaft_pos = shaft_pos - step;
        shaft_pos = shaft_pos % modulus;
        if (shaft_pos < 0) shaft_pos = shaft_pos + modulus;
        send_raw(shaft_pos[RAW_W-1:0]);
      end
    end
  endtask

  // First sample, start mode held, zone edges, both crossings through the wrap
  task automatic test_start_and_edges();
    int unsigned seq[$] = '{0, 500, 65535, 35000, 999, 1000, 17999, 18000, 35000,
                            35001, 999, 1000, 500, 65535, 20000, 0, 17000, 200,
                            35500, 34000, 36000};
    foreach (seq[i]) send_raw(seq[i][RAW_W-1:0]);
  endtask

  // Default edges, slow turning both ways with some noise
  task automatic test_default_walk();
    shaft_pos = 20000;
    rotate(50, 85, 1, 3000, 10);
    rotate(50, 15, 1, 3000, 10);
  endtask

  // Long receiver hold while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    send_gaps_on = 1'b0;
    hold_request = 1'b1;
    rotate(40, 80, 100, 2500, 5);
    send_gaps_on = 1'b1;
    drain_results();
    rotate(30, 30, 100, 2500, 10);
    // a stretch with no idling on either side
    send_gaps_on   = 1'b0;
    recv_stalls_on = 1'b0;
    rotate(40, 60, 100, 2500, 10);
    send_gaps_on   = 1'b1;
    recv_stalls_on = 1'b1;
  endtask

  // Register extremes, out-of-order edges and zero span
  task automatic test_register_extremes();
    logic [RAW_W-1:0] a, b, c;
    set_registers(16'd0, 16'd0, 16'd0, 16'd1);
    rotate(35, 50, 1, 20000, 40);
    set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    rotate(35, 50, 1, 20000, 40);
    set_registers(16'd40000, 16'd20000, 16'd10000, 16'hFFFF);
    rotate(35, 50, 1, 20000, 40);
    set_registers(16'd0, 16'd32768, 16'hFFFF, 16'hFFFF);
    rotate(35, 50, 1, 20000, 40);
    set_registers(16'd100, 16'd200, 16'd300, 16'd0);
    rotate(35, 50, 1, 150, 30);
    // sorted random edges with a random span
    a = RAW_W'($urandom_range(0, 20000));
    b = a + RAW_W'($urandom_range(0, 20000));
    c = b + RAW_W'($urandom_range(0, 20000));
    set_registers(a, b, c, c + SPAN_W'($urandom_range(1, 5000)));
    rotate(35, 60, 1, 6000, 15);
  endtask

  // Equal zones and steps shorter than a zone: every turn counts, so a long
  // spin runs the turn count past its positive limit and back past the negative one
  task automatic test_turn_wraparound();
    set_registers(16'd9000, 16'd18000, 16'd27000, 16'd36000);
    shaft_pos = 20000;
    rotate(660, 100, 6000, 8900, 0);
    rotate(100, 0, 6000, 8900, 0);
  endtask

  // Receiver readiness, driven at the falling edge
  initial begin
    m_axis_tready = 1'b0;
    hold_left     = 0;
    stall_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = 80;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        m_axis_tready <= 1'b1;
        if (recv_stalls_on) stall_left = pick_gap();
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  initial begin
    angle_result_t got;
    angle_result_t want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.unwrapped = m_axis_tdata[ANGLE_W-1:0];
        got.filtered  = m_axis_tdata[ANGLE_W +: ANGLE_W];
        got.mode      = mode_e'(m_axis_tdata[2*ANGLE_W +: MODE_W]);
        got.averaged  = m_axis_tuser;
        if (expected_angles.size() == 0) begin
          $error("result with no item pending: unwrapped_angle %0d", got.unwrapped);
          error_count++;
        end else begin
          want = expected_angles.pop_front();
          if (got.unwrapped !== want.unwrapped) begin
            $error("unwrapped_angle: expected %0d, got %0d", want.unwrapped, got.unwrapped);
            error_count++;
          end
          if (got.filtered !== want.filtered) begin
            $error("filtered_angle: expected %0d, got %0d", want.filtered, got.filtered);
            error_count++;
          end
          if (got.mode !== want.mode) begin
            $error("crossing_mode: expected %0d, got %0d", want.mode, got.mode);
            error_count++;
          end
          if (got.averaged !== want.averaged) begin
            $error("sample_averaged: expected %0d, got %0d", want.averaged, got.averaged);
            error_count++;
          end
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_LOW_EDGE;
    cfg_data_i      = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    error_count     = 0;
    shaft_pos       = 0;
    send_gaps_on    = 1'b1;
    recv_stalls_on  = 1'b1;
    hold_request    = 1'b0;
    edge_lo         = LOW_EDGE_RST;
    edge_mid        = MID_EDGE_RST;
    edge_hi         = HIGH_EDGE_RST;
    turn_span       = FULL_TURN_RST;
    foreach (window_q[i]) window_q[i] = 0;
    slot_q          = 0;
    window_sum_q    = 0;
    mean_q          = 0;
    turn_count_q    = '0;
    mode_q          = MODE_START;
    last_zone_q     = ZONE_NONE;
    window_primed_q = 1'b0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_start_and_edges();
    test_default_walk();
    test_backpressure();
    test_register_extremes();
    test_turn_wraparound();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("angle_unwrap_moving_average_core test passed");
    end else begin
      $display("angle_unwrap_moving_average_core test failed");
    end
    $finish;
  end

endmodule
